// File: rtl/core/p256o_pkg.sv
// shared constants for the p-256 group order scalar unit
package p256o_pkg;
    localparam int WordW = 64;
    localparam int ValW  = 256;

    localparam logic [2:0] OP_MUL  = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_INV  = 3'd2;
    localparam logic [2:0] OP_RED  = 3'd3;
    localparam logic [2:0] OP_RED2 = 3'd4;

    localparam logic [ValW-1:0] ORDER_N =
        256'hffffffff00000000ffffffffffffffffbce6faada7179e84f3b9cac2fc632551;
    localparam logic [ValW-1:0] ORDER_N_M2 =
        256'hffffffff00000000ffffffffffffffffbce6faada7179e84f3b9cac2fc63254f;

    // one conditional subtraction of n
    function automatic logic [ValW-1:0] cond_sub(input logic [ValW-1:0] v);
        logic [ValW:0] d;
        d = {1'b0, v} - {1'b0, ORDER_N};
        cond_sub = d[ValW] ? v : d[ValW-1:0];
    endfunction
endpackage

// File: rtl/core/p256_order_scalar_alu.sv
// top level of the p-256 group order scalar unit
// Operand words load one per cycle while the unit is idle into an eight-word store; the
// word flagged last starts the operation. Multiply takes one bit per cycle through a
// serial modular multiplier. Add and reduce 256 are computed in state S_MUL and go
// straight to output. Reduce 512 shifts the wide value through a one-bit long divider.
// Inverse runs x^(n-2) by square-and-multiply on the same multiplier, 512 products in
// all. Four result words then leave, and no new word is taken until the last of them
// is delivered.
module p256_order_scalar_alu (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_opcode,
    input  logic [2:0]  i_word_index,
    input  logic [63:0] i_data_word,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_result_word,
    output logic [1:0]  o_result_index,
    output logic        o_result_last
);
    localparam int W = p256o_pkg::ValW;
    localparam logic [2:0] S_IDLE = 3'd0, S_MUL = 3'd1, S_RED = 3'd2,
                           S_SQ = 3'd3, S_XM = 3'd4, S_OUT = 3'd5;

    logic [2:0]   r_state;
    logic [63:0]  r_store [8];
    logic [W-1:0] r_val, r_base, r_a, r_b, r_xa;
    logic [W-1:0] r_wide;
    logic [2:0]   r_cnt;
    logic [8:0]   r_ebit;
    logic [1:0]   r_oidx;
    logic         r_mstart;
    logic         mul_done;
    logic [W-1:0] mul_prod;
    logic         acc_in;
    logic [W:0]   rsh, rsub;
    logic [W-1:0] a_red, b_red, op_a, op_b;
    logic         exp_bit_sel;
    logic [W:0]   sum;

    wire take = i_valid && !o_stall;

    assign o_stall = (r_state != S_IDLE);
    assign op_a = {r_store[3], r_store[2], r_store[1], r_store[0]};
    assign op_b = {r_store[7], r_store[6], r_store[5], r_store[4]};
    assign exp_bit_sel = p256o_pkg::ORDER_N_M2[r_ebit[7:0]];

    p256o_modmul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_mstart),
        .i_a(r_a), .i_b(r_b), .o_done(mul_done), .o_prod(mul_prod)
    );

    // one step of binary long division for the wide reduce
    always_comb begin
        acc_in = r_wide[W-1];
        rsh  = {r_val, acc_in};
        rsub = rsh - {1'b0, p256o_pkg::ORDER_N};
    end

    always_ff @(posedge i_clk) begin
        if (take) r_store[i_word_index] <= i_data_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mstart <= 1'b0;
            r_oidx   <= '0;
        end else begin
            r_mstart <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (take && i_last) begin
                        case (i_opcode) inside
                            p256o_pkg::OP_MUL, p256o_pkg::OP_ADD,
                            p256o_pkg::OP_INV, p256o_pkg::OP_RED,
                            p256o_pkg::OP_RED2: r_state <= S_MUL;
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_MUL: begin
                    // operands now complete in the store
                    r_oidx <= '0;
                    if (r_cnt[2:0] == p256o_pkg::OP_RED2) begin
                        r_state <= S_RED;
                    end else if (r_cnt[2:0] == p256o_pkg::OP_MUL) begin
                        r_state  <= S_XM;
                        r_mstart <= 1'b1;
                    end else if (r_cnt[2:0] == p256o_pkg::OP_INV) begin
                        r_state  <= S_SQ;
                        r_mstart <= 1'b1;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_RED: if (r_ebit == 9'd511) r_state <= S_OUT;
                S_SQ: if (mul_done) begin
                    r_state  <= S_XM;
                    r_mstart <= 1'b1;
                end
                S_XM: if (mul_done) begin
                    if (r_cnt[2:0] == p256o_pkg::OP_INV && r_ebit != 9'd0) begin
                        r_state  <= S_SQ;
                        r_mstart <= 1'b1;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: if (!i_stall) begin
                    r_oidx <= r_oidx + 2'd1;
                    if (r_oidx == 2'd3) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign a_red = p256o_pkg::cond_sub(op_a);
    assign b_red = p256o_pkg::cond_sub(op_b);
    assign sum   = {1'b0, a_red} + {1'b0, b_red};

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: if (take) r_cnt <= i_opcode;
            S_MUL: begin
                r_ebit <= 9'd255;
                r_xa   <= a_red;
                r_val  <= '0;
                r_wide <= op_b;
                r_base <= op_a;
                if (r_cnt[2:0] == p256o_pkg::OP_MUL) begin
                    r_a <= a_red;
                    r_b <= b_red;
                end else if (r_cnt[2:0] == p256o_pkg::OP_INV) begin
                    r_a <= {{(W-1){1'b0}}, 1'b1};
                    r_b <= {{(W-1){1'b0}}, 1'b1};
                    r_val <= {{(W-1){1'b0}}, 1'b1};
                end else if (r_cnt[2:0] == p256o_pkg::OP_ADD) begin
                    r_val <= p256o_pkg::cond_sub(sum[W] ? sum[W-1:0] -
                             p256o_pkg::ORDER_N : sum[W-1:0]);
                end else if (r_cnt[2:0] == p256o_pkg::OP_RED) begin
                    r_val <= a_red;
                end else begin
                    r_ebit <= 9'd0;
                end
            end
            S_RED: begin
                r_val  <= (rsh[W] || !rsub[W]) ? rsub[W-1:0] : rsh[W-1:0];
                r_wide <= {r_wide[W-2:0], r_base[W-1]};
                r_base <= {r_base[W-2:0], 1'b0};
                r_ebit <= r_ebit + 9'd1;
            end
            S_SQ: if (mul_done) begin
                r_val <= mul_prod;
                r_a   <= mul_prod;
                r_b   <= exp_bit_sel ? r_xa : {{(W-1){1'b0}}, 1'b1};
            end
            S_XM: if (mul_done) begin
                r_val <= mul_prod;
                r_a   <= mul_prod;
                r_b   <= mul_prod;
                if (r_ebit != 9'd0) r_ebit <= r_ebit - 9'd1;
            end
            default: ;
        endcase
    end

    assign o_valid        = (r_state == S_OUT);
    assign o_result_word  = r_val[64*r_oidx +: 64];
    assign o_result_index = r_oidx;
    assign o_result_last  = (r_oidx == 2'd3);

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !take) else $error("input taken while busy");
    a_out_below_n: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_val < p256o_pkg::ORDER_N)) else $error("result not reduced");
    a_out_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && r_oidx != 2'd3) |=> (o_valid && r_oidx == $past(r_oidx) + 2'd1))
        else $error("result words out of order");
endmodule

// File: rtl/core/p256o_modmul.sv
// bit-serial modular multiply: one multiplier bit per cycle, msb first
module p256o_modmul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [p256o_pkg::ValW-1:0]  i_a,
    input  logic [p256o_pkg::ValW-1:0]  i_b,
    output logic                        o_done,
    output logic [p256o_pkg::ValW-1:0]  o_prod
);
    localparam int W = p256o_pkg::ValW;

    logic [W-1:0] r_acc, n_acc, r_a, r_b;
    logic [8:0]   r_cnt;
    logic         r_busy, r_done;
    logic [W+1:0] dbl, s1;
    logic [W+1:0] t1, t2;

    // acc = 2*acc + bit*a, each reduced; operands are below n
    always_comb begin
        dbl = {r_acc, 1'b0};
        t1 = dbl - {2'b0, p256o_pkg::ORDER_N};
        s1 = t1[W+1] ? dbl : t1;
        s1 = s1 + (r_b[W-1] ? {2'b0, r_a} : '0);
        t2 = s1 - {2'b0, p256o_pkg::ORDER_N};
        n_acc = t2[W+1] ? s1[W-1:0] : t2[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 9'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 9'd1;
                if (r_cnt == 9'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_b   <= {r_b[W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule
